// ----- rtl/core/srttrp_pkg.sv -----
// ----------------------------------------------------------------------------
// srttrp_pkg
// Types and constants shared by the subtitle time range parser.
// ----------------------------------------------------------------------------
package srttrp_pkg;

    localparam int unsigned TIME_W = 29;
    localparam int unsigned ACC_W  = 10;
    localparam int unsigned POS_W  = 4;

    localparam logic [POS_W-1:0] TIME_BYTES = 4'd12;

    // Byte positions inside one time: the separators and the last digit of each field.
    localparam logic [POS_W-1:0] POS_HOUR_SEP = 4'd2;
    localparam logic [POS_W-1:0] POS_MIN_SEP  = 4'd5;
    localparam logic [POS_W-1:0] POS_SEC_SEP  = 4'd8;
    localparam logic [POS_W-1:0] POS_HOUR_END = 4'd1;
    localparam logic [POS_W-1:0] POS_MIN_END  = 4'd4;
    localparam logic [POS_W-1:0] POS_SEC_END  = 4'd7;
    localparam logic [POS_W-1:0] POS_MS_END   = 4'd11;

    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_DASH   = 8'h2D;
    localparam logic [7:0] CHAR_PERIOD = 8'h2E;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_GT     = 8'h3E;

    localparam logic [ACC_W-1:0] UNIT_LIMIT = 10'd60;

    typedef enum logic [1:0] {
        PHASE_SEARCH = 2'd0,
        PHASE_SKIP   = 2'd1,
        PHASE_END    = 2'd2,
        PHASE_DONE   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       line_end;
    } in_item_t;

    typedef struct packed {
        logic              range_valid;
        logic [TIME_W-1:0] start_time_ms;
        logic [TIME_W-1:0] end_time_ms;
    } out_item_t;

    // Running state of one time field while it is being read.
    typedef struct packed {
        logic [ACC_W-1:0]  acc;
        logic [TIME_W-1:0] value;
        logic              good;
    } time_state_t;

endpackage

// ----- rtl/core/srt_time_range_parser_unit.sv -----
// ----------------------------------------------------------------------------
// srt_time_range_parser_unit
// The last byte of a line is held in the input register; its result is then captured in the result register.
// Throughput: one byte per cycle; the parse state updates once per byte.
// Only a last byte waits on a full, stalled result register.
// Reset: rst_n empties the input and result registers and clears the line state.
// ----------------------------------------------------------------------------
module srt_time_range_parser_unit
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  srttrp_pkg::in_item_t  item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output srttrp_pkg::out_item_t result
);
    import srttrp_pkg::*;

    logic      in_valid_reg, in_valid_next;
    in_item_t  in_item_reg;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg;

    logic      out_free;
    logic      core_step;
    logic      item_accept;
    logic      core_fire;
    out_item_t core_result;

    assign out_free    = !out_valid_reg || !result_stall;
    // A byte that ends no line gives no result, so only the last byte waits.
    assign core_step   = in_valid_reg && (!in_item_reg.line_end || out_free);
    assign item_stall  = in_valid_reg && !core_step;
    assign item_accept = item_valid && !item_stall;

    srttrp_parse_core u_parse_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (core_step),
        .item        (in_item_reg),
        .result_fire (core_fire),
        .result      (core_result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (item_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (core_step)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (core_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            in_item_reg <= item;
        end
        if (core_fire)
        begin
            out_item_reg <= core_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule

// ----- rtl/core/srttrp_time_step.sv -----
// ----------------------------------------------------------------------------
// srttrp_time_step
// Folds one byte of an HH:MM:SS,mmm or HH:MM:SS.mmm time into the running field state.
// ----------------------------------------------------------------------------
module srttrp_time_step
(
    input  logic [srttrp_pkg::POS_W-1:0] pos,
    input  logic [7:0]                   char_code,
    input  srttrp_pkg::time_state_t      state_in,
    output srttrp_pkg::time_state_t      state_out
);
    import srttrp_pkg::*;

    logic             is_digit;
    logic [3:0]       digit;
    logic [13:0]      acc_scaled;
    logic [ACC_W-1:0] acc_new;
    logic [34:0]      mul60;
    logic [38:0]      mul1000;

    assign is_digit   = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    assign digit      = 4'(char_code - CHAR_ZERO);
    assign acc_scaled = {4'b0, state_in.acc} * 14'd10 + {10'b0, digit};
    assign acc_new    = acc_scaled[ACC_W-1:0];
    assign mul60      = {6'b0, state_in.value} * 35'd60 + {25'b0, acc_new};
    assign mul1000    = {10'b0, state_in.value} * 39'd1000 + {29'b0, acc_new};

    always_comb
    begin
        state_out = state_in;
        if ((pos == POS_HOUR_SEP) || (pos == POS_MIN_SEP))
        begin
            if (char_code != CHAR_COLON)
            begin
                state_out.good = 1'b0;
            end
            state_out.acc = '0;
        end
        else if (pos == POS_SEC_SEP)
        begin
            if ((char_code != CHAR_COMMA) && (char_code != CHAR_PERIOD))
            begin
                state_out.good = 1'b0;
            end
            state_out.acc = '0;
        end
        else if (!is_digit)
        begin
            state_out.good = 1'b0;
        end
        else
        begin
            state_out.acc = acc_new;
            if (state_in.good)
            begin
                if (pos == POS_HOUR_END)
                begin
                    state_out.value = {{(TIME_W-ACC_W){1'b0}}, acc_new};
                end
                else if ((pos == POS_MIN_END) || (pos == POS_SEC_END))
                begin
                    if (acc_new >= UNIT_LIMIT)
                    begin
                        state_out.good = 1'b0;
                    end
                    else
                    begin
                        state_out.value = mul60[TIME_W-1:0];
                    end
                end
                else if (pos == POS_MS_END)
                begin
                    state_out.value = mul1000[TIME_W-1:0];
                end
            end
        end
    end

endmodule

// ----- rtl/core/srttrp_parse_core.sv -----
// ----------------------------------------------------------------------------
// srttrp_parse_core
// Line state: start time, arrow search, whitespace skip and end time.
// ----------------------------------------------------------------------------
module srttrp_parse_core
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  srttrp_pkg::in_item_t  item,
    output logic                  result_fire,
    output srttrp_pkg::out_item_t result
);
    import srttrp_pkg::*;

    logic [POS_W-1:0]  start_pos_reg,   start_pos_next;
    logic [TIME_W-1:0] start_value_reg, start_value_next;
    logic              start_good_reg,  start_good_next;
    logic [1:0]        arrow_reg,       arrow_next;
    phase_t            phase_reg,       phase_next;
    logic [POS_W-1:0]  end_pos_reg,     end_pos_next;
    logic [TIME_W-1:0] end_value_reg,   end_value_next;
    logic              end_good_reg,    end_good_next;
    logic [ACC_W-1:0]  acc_reg,         acc_next;

    logic             use_end;
    logic [POS_W-1:0] ts_pos;
    time_state_t      ts_in;
    time_state_t      ts_out;
    logic             is_space;
    logic [POS_W-1:0] end_pos_inc;
    logic             valid;

    assign use_end      = (phase_reg != PHASE_SEARCH);
    assign ts_pos       = use_end ? end_pos_reg : start_pos_reg;
    // Leaving the whitespace skip starts the end time with a cleared field.
    assign ts_in.acc    = (phase_reg == PHASE_SKIP) ? '0 : acc_reg;
    assign ts_in.value  = use_end ? end_value_reg : start_value_reg;
    assign ts_in.good   = use_end ? end_good_reg : start_good_reg;
    assign is_space     = (item.char_code == CHAR_SPACE) ||
                          ((item.char_code >= CHAR_TAB) && (item.char_code <= CHAR_CR));
    assign end_pos_inc  = end_pos_reg + 4'd1;

    srttrp_time_step u_time_step
    (
        .pos       (ts_pos),
        .char_code (item.char_code),
        .state_in  (ts_in),
        .state_out (ts_out)
    );

    always_comb
    begin
        start_pos_next   = start_pos_reg;
        start_value_next = start_value_reg;
        start_good_next  = start_good_reg;
        arrow_next       = arrow_reg;
        phase_next       = phase_reg;
        end_pos_next     = end_pos_reg;
        end_value_next   = end_value_reg;
        end_good_next    = end_good_reg;
        acc_next         = acc_reg;

        unique case (phase_reg)
            PHASE_SEARCH:
            begin
                if (start_pos_reg < TIME_BYTES)
                begin
                    start_value_next = ts_out.value;
                    start_good_next  = ts_out.good;
                    acc_next         = ts_out.acc;
                    start_pos_next   = start_pos_reg + 4'd1;
                end
                priority if (item.char_code == CHAR_NUL)
                begin
                    phase_next = PHASE_DONE;
                end
                else if (item.char_code == CHAR_DASH)
                begin
                    if (arrow_reg < 2'd2)
                    begin
                        arrow_next = arrow_reg + 2'd1;
                    end
                end
                else if ((item.char_code == CHAR_GT) && (arrow_reg == 2'd2))
                begin
                    arrow_next = '0;
                    phase_next = PHASE_SKIP;
                end
                else
                begin
                    arrow_next = '0;
                end
            end
            PHASE_SKIP, PHASE_END:
            begin
                if ((phase_reg == PHASE_END) || !is_space)
                begin
                    end_value_next = ts_out.value;
                    end_good_next  = ts_out.good;
                    acc_next       = ts_out.acc;
                    end_pos_next   = end_pos_inc;
                    phase_next     = (end_pos_inc >= TIME_BYTES) ? PHASE_DONE : PHASE_END;
                end
            end
            PHASE_DONE:
            begin
            end
        endcase
    end

    assign valid = start_good_next && (start_pos_next == TIME_BYTES) &&
                   end_good_next && (end_pos_next == TIME_BYTES) &&
                   (end_value_next > start_value_next);

    assign result_fire          = step && item.line_end;
    assign result.range_valid   = valid;
    assign result.start_time_ms = valid ? start_value_next : '0;
    assign result.end_time_ms   = valid ? end_value_next : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pos_reg   <= '0;
            start_value_reg <= '0;
            start_good_reg  <= 1'b1;
            arrow_reg       <= '0;
            phase_reg       <= PHASE_SEARCH;
            end_pos_reg     <= '0;
            end_value_reg   <= '0;
            end_good_reg    <= 1'b1;
            acc_reg         <= '0;
        end
        else if (result_fire)
        begin
            // The last byte of a line returns everything to the idle state.
            start_pos_reg   <= '0;
            start_value_reg <= '0;
            start_good_reg  <= 1'b1;
            arrow_reg       <= '0;
            phase_reg       <= PHASE_SEARCH;
            end_pos_reg     <= '0;
            end_value_reg   <= '0;
            end_good_reg    <= 1'b1;
            acc_reg         <= '0;
        end
        else if (step)
        begin
            start_pos_reg   <= start_pos_next;
            start_value_reg <= start_value_next;
            start_good_reg  <= start_good_next;
            arrow_reg       <= arrow_next;
            phase_reg       <= phase_next;
            end_pos_reg     <= end_pos_next;
            end_value_reg   <= end_value_next;
            end_good_reg    <= end_good_next;
            acc_reg         <= acc_next;
        end
    end

endmodule

// ----- tb/srt_time_range_parser_unit_tb.sv -----
// ----------------------------------------------------------------------------
// srt_time_range_parser_unit_tb
// Feeds subtitle timing lines into the range parser one byte per request and
// checks every parsed range against an in-bench model of the line parser.
// Directed lines cover the field extremes and the malformed cases. They are
// followed by random lines, mostly well formed, under three stall mixes.
// ----------------------------------------------------------------------------
module srt_time_range_parser_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import srttrp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned MAX_TIME_MS = 359999999;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    in_item_t  item;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result;

    // Parse state of the line in flight, as the block should hold it.
    logic [POS_W-1:0]  start_pos;
    logic [POS_W-1:0]  end_pos;
    logic [TIME_W-1:0] start_val;
    logic [TIME_W-1:0] end_val;
    logic              start_ok;
    logic              end_ok;
    logic [1:0]        dash_run;
    phase_t            phase;
    logic [ACC_W-1:0]  acc;

    out_item_t   expected_ranges[$];
    logic [7:0]  line_buf[$];
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned errors;
    int unsigned lines_sent;
    int unsigned bytes_sent;
    int unsigned good_ranges;
    int unsigned ranges_checked;
    int unsigned cycle_count;

    srt_time_range_parser_unit dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(negedge clk)
    begin
        result_stall <= rst_n && ($urandom_range(0, 99) < rx_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Line model
    // ------------------------------------------------------------------------
    function automatic logic is_blank(input logic [7:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    // One byte of a time at byte position pos; the accumulator is shared by
    // both times and is only cleared at separators, before the end time and at line end.
    function automatic time_state_t time_char(input logic [POS_W-1:0] pos,
                                              input logic [7:0] c,
                                              input time_state_t s);
        time_state_t r;
        r = s;
        if (pos == POS_HOUR_SEP || pos == POS_MIN_SEP)
        begin
            if (c != CHAR_COLON)
                r.good = 1'b0;
            r.acc = '0;
        end
        else if (pos == POS_SEC_SEP)
        begin
            if (c != CHAR_COMMA && c != CHAR_PERIOD)
                r.good = 1'b0;
            r.acc = '0;
        end
        else if (c < CHAR_ZERO || c > CHAR_NINE)
        begin
            r.good = 1'b0;
        end
        else
        begin
            r.acc = ACC_W'(s.acc * 10 + (c - CHAR_ZERO));
            if (r.good)
            begin
                if (pos == POS_HOUR_END)
                    r.value = TIME_W'(r.acc);
                else if (pos == POS_MIN_END || pos == POS_SEC_END)
                begin
                    if (r.acc >= UNIT_LIMIT)
                        r.good = 1'b0;
                    else
                        r.value = TIME_W'(s.value * 60 + r.acc);
                end
                else if (pos == POS_MS_END)
                    r.value = TIME_W'(s.value * 1000 + r.acc);
            end
        end
        return r;
    endfunction

    task clear_line_state();
        start_pos = '0;
        end_pos   = '0;
        start_val = '0;
        end_val   = '0;
        start_ok  = 1'b1;
        end_ok    = 1'b1;
        dash_run  = '0;
        phase     = PHASE_SEARCH;
        acc       = '0;
    endtask

    task automatic parse_byte(input in_item_t it);
        time_state_t ts;
        out_item_t   want;
        logic [7:0]  c;
        logic        ok;
        c = it.char_code;
        case (phase)
            PHASE_SEARCH:
            begin
                if (start_pos < TIME_BYTES)
                begin
                    ts.acc   = acc;
                    ts.value = start_val;
                    ts.good  = start_ok;
                    ts = time_char(start_pos, c, ts);
                    acc       = ts.acc;
                    start_val = ts.value;
                    start_ok  = ts.good;
                    start_pos++;
                end
                if (c == CHAR_NUL)
                    phase = PHASE_DONE;
                else if (c == CHAR_DASH)
                begin
                    if (dash_run < 2'd2)
                        dash_run++;
                end
                else if (c == CHAR_GT && dash_run == 2'd2)
                begin
                    dash_run = '0;
                    phase    = PHASE_SKIP;
                end
                else
                    dash_run = '0;
            end
            PHASE_SKIP, PHASE_END:
            begin
                // The first non-blank byte after the arrow opens the end time.
                if (phase == PHASE_SKIP && !is_blank(c))
                begin
                    phase = PHASE_END;
                    acc   = '0;
                end
                if (phase == PHASE_END)
                begin
                    ts.acc   = acc;
                    ts.value = end_val;
                    ts.good  = end_ok;
                    ts = time_char(end_pos, c, ts);
                    acc     = ts.acc;
                    end_val = ts.value;
                    end_ok  = ts.good;
                    end_pos++;
                    if (end_pos >= TIME_BYTES)
                        phase = PHASE_DONE;
                end
            end
            default:
            begin
            end
        endcase
        if (it.line_end)
        begin
            ok = start_ok && start_pos == TIME_BYTES && end_ok && end_pos == TIME_BYTES
                 && end_val > start_val;
            want.range_valid   = ok;
            want.start_time_ms = ok ? start_val : '0;
            want.end_time_ms   = ok ? end_val : '0;
            expected_ranges.push_back(want);
            if (ok)
                good_ranges++;
            lines_sent++;
            clear_line_state();
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_ranges.size() == 0)
            begin
                $display("%0t: unexpected range, expected none, got valid=%0b %0d..%0d",
                         $time, result.range_valid, result.start_time_ms, result.end_time_ms);
                errors++;
            end
            else
            begin
                want = expected_ranges.pop_front();
                ranges_checked++;
                if (result.range_valid !== want.range_valid)
                begin
                    $display("%0t: range_valid expected %0b, got %0b",
                             $time, want.range_valid, result.range_valid);
                    errors++;
                end
                if (result.start_time_ms !== want.start_time_ms)
                begin
                    $display("%0t: start_time_ms expected %0d, got %0d",
                             $time, want.start_time_ms, result.start_time_ms);
                    errors++;
                end
                if (result.end_time_ms !== want.end_time_ms)
                begin
                    $display("%0t: end_time_ms expected %0d, got %0d",
                             $time, want.end_time_ms, result.end_time_ms);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    task automatic send_byte(input in_item_t it);
        @(negedge clk);
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            item_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < tx_idle_pct);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        bytes_sent++;
        parse_byte(it);
    endtask

    task automatic send_line();
        in_item_t it;
        int       i;
        for (i = 0; i < line_buf.size(); i++)
        begin
            it.char_code = line_buf[i];
            it.line_end  = (i == line_buf.size() - 1);
            send_byte(it);
        end
        line_buf.delete();
    endtask

    // Holds off new requests until every pending range has been checked.
    task wait_for_ranges();
        @(negedge clk);
        item_valid <= 1'b0;
        while (expected_ranges.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task automatic push_time(input int unsigned hh, input int unsigned mm,
                             input int unsigned ss, input int unsigned ms,
                             input logic [7:0] sep);
        line_buf.push_back(8'(CHAR_ZERO + hh / 10));
        line_buf.push_back(8'(CHAR_ZERO + hh % 10));
        line_buf.push_back(CHAR_COLON);
        line_buf.push_back(8'(CHAR_ZERO + mm / 10));
        line_buf.push_back(8'(CHAR_ZERO + mm % 10));
        line_buf.push_back(CHAR_COLON);
        line_buf.push_back(8'(CHAR_ZERO + ss / 10));
        line_buf.push_back(8'(CHAR_ZERO + ss % 10));
        line_buf.push_back(sep);
        line_buf.push_back(8'(CHAR_ZERO + ms / 100));
        line_buf.push_back(8'(CHAR_ZERO + (ms / 10) % 10));
        line_buf.push_back(8'(CHAR_ZERO + ms % 10));
    endtask

    task automatic text_line(input string s);
        push_text(s);
        send_line();
    endtask

    function automatic logic [7:0] random_blank();
        int unsigned r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CHAR_SPACE : 8'(CHAR_TAB + r);
    endfunction

    function automatic logic [7:0] random_sep();
        return $urandom_range(0, 1) ? CHAR_COMMA : CHAR_PERIOD;
    endfunction

    function automatic int unsigned random_unit();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(60, 99) : $urandom_range(0, 59);
    endfunction

    // Mostly well-formed lines with random fields; the rest is pure noise or
    // lines with a broken arrow, a corrupted byte or a truncated tail.
    task automatic build_random_line();
        int unsigned pick, n, hh, mm, ss, ms, t0, t1;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            n = $urandom_range(1, 40);
            repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            case ($urandom_range(0, 4))
                0:       hh = 0;
                1:       hh = 99;
                default: hh = $urandom_range(0, 99);
            endcase
            mm = random_unit();
            ss = random_unit();
            ms = $urandom_range(0, 999);
            push_time(hh, mm, ss, ms, random_sep());
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
            if ($urandom_range(0, 4) != 0)
                line_buf.push_back(CHAR_SPACE);
            case ($urandom_range(0, 19))
                0:       push_text("->");
                1:       push_text("-- >");
                2, 3:    push_text("--->");
                default: push_text("-->");
            endcase
            repeat ($urandom_range(0, 3)) line_buf.push_back(random_blank());
            t0 = ((hh * 60 + mm) * 60 + ss) * 1000 + ms;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: t1 = t0 + $urandom_range(1, 10000);
                6:                t1 = t0;
                7:                t1 = t0 / 2;
                default:          t1 = $urandom_range(0, MAX_TIME_MS);
            endcase
            if (t1 > MAX_TIME_MS)
                t1 = MAX_TIME_MS;
            push_time(t1 / 3600000, (t1 / 60000) % 60, (t1 / 1000) % 60, t1 % 1000,
                      random_sep());
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 9) == 0)
                line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 11) == 0)
            begin
                n = $urandom_range(1, line_buf.size() - 1);
                while (line_buf.size() > n)
                    void'(line_buf.pop_back());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task test_valid_ranges();
        text_line("00:00:00,000 --> 99:59:59,999");
        text_line("12:34:56.789-->12:34:56.790");
        // Every kind of blank between the arrow and the end time, then a tail.
        push_text("01:02:03,004 -->");
        line_buf.push_back(CHAR_TAB);
        line_buf.push_back(8'h0A);
        line_buf.push_back(8'h0B);
        line_buf.push_back(8'h0C);
        line_buf.push_back(CHAR_CR);
        line_buf.push_back(CHAR_SPACE);
        push_text("01:02:03,005 x -->");
        send_line();
        wait_for_ranges();
    endtask

    task test_malformed_times();
        text_line("00:00:0");
        text_line("00:60:00,000 --> 00:00:01,000");
        text_line("00:00:60,000 --> 00:01:00,000");
        text_line("00:00:00;000 --> 00:00:01,000");
        text_line("00:00-->00:00:01,000");
        text_line("00:00:00,000 00:00:01,000");
        text_line("00:00:05,000 --> 00:00:05,000");
        text_line("00:00:05,000 --> 00:00:04,999");
        text_line("00:00:00,000 --> 00:0a:01,000");
        text_line("00:00:00,000 --> 00:00:01");
        wait_for_ranges();
    endtask

    task test_arrows_and_zero_bytes();
        text_line("00:00:00,000 ---> 00:00:01,000");
        text_line("00:00:00,000 -- > 00:00:01,000");
        push_text("00:00:00,000");
        line_buf.push_back(CHAR_NUL);
        push_text(" --> 00:00:01,000");
        send_line();
        push_text("00:00:00,000 --> 00:00");
        line_buf.push_back(CHAR_NUL);
        push_text("1,000");
        send_line();
        line_buf.push_back(8'hFF);
        send_line();
        wait_for_ranges();
    endtask

    task automatic test_random_lines(input int unsigned byte_budget);
        int unsigned start_bytes;
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < byte_budget)
        begin
            build_random_line();
            send_line();
            if ($urandom_range(0, 19) == 0)
                wait_for_ranges();
        end
        wait_for_ranges();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        item           = '0;
        errors         = 0;
        lines_sent     = 0;
        bytes_sent     = 0;
        good_ranges    = 0;
        ranges_checked = 0;
        tx_idle_pct    = 24;
        rx_idle_pct    = 54;
        clear_line_state();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_valid_ranges();
        test_malformed_times();
        test_arrows_and_zero_bytes();
        test_random_lines(150);

        tx_idle_pct = 54;
        rx_idle_pct = 24;
        test_random_lines(150);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_lines(150);

        wait_for_ranges();
        repeat (8) @(posedge clk);

        $display("Parsed %0d lines (%0d bytes), %0d ranges checked, %0d of them valid,",
                 lines_sent, bytes_sent, ranges_checked, good_ranges);
        $display("with directed malformed lines and random traffic under three stall mixes.");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
